[rtl/diwvf_pkg.sv]
// Shared types and register codes for the digital input window vote filter.
package diwvf_pkg;

   // Register index port width (two registers, spare codes are ignored)
   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_POLARITY = 2'd0,
      CSR_ENABLE   = 2'd1
   } csr_index_type;

   // Per-lane control from the ring controller
   typedef struct packed {
      logic accept;     // sample transaction taken this cycle
      logic old_valid;  // evicted ring entry holds a real written sample
   } lane_ctrl_type;

endpackage

[rtl/digital_input_window_vote_filter_core.sv]
// Top level: sample ring, per-channel vote lanes and result merge.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_raw_sample
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_adjusted_level, rsp_masked_status
//  csr     | in        | csr_write_en         | csr_index, csr_wdata
//
// One sample transaction per cycle while req_stall is low; its result is registered and offered from the merge buffer.
// The evicted ring entry is fetched through the registered read port from the next write slot.
// Reset clears counts, index and a wrap flag; the RAM is not swept, entries before the
// first wrap count as zeros.
// Results sit in a two-entry buffer; req_stall rises only when both entries are full.
module digital_input_window_vote_filter_core #(
   parameter int SAMPLE_DEPTH = 16,
   parameter int CHANNELS     = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [CHANNELS-1:0]                 req_raw_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [CHANNELS-1:0]                 rsp_adjusted_level,
   output logic [CHANNELS-1:0]                 rsp_masked_status,
   input  logic                                csr_write_en,
   input  logic [diwvf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [CHANNELS-1:0]                 csr_wdata
);
   import diwvf_pkg::*;

   localparam int IW = $clog2(SAMPLE_DEPTH);
   localparam logic [IW-1:0] IDX_LAST = IW'(SAMPLE_DEPTH - 1);

   logic                req_accept;
   logic [IW-1:0]       idx_ff;
   logic [IW-1:0]       idx_in;
   logic                wrapped_ff;
   logic [IW-1:0]       rd_addr;
   logic [CHANNELS-1:0] old_sample;
   logic [CHANNELS-1:0] level;
   logic [CHANNELS-1:0] polarity_ff;
   logic [CHANNELS-1:0] enable_ff;
   lane_ctrl_type       lane_ctrl;

   assign req_accept = req_valid & ~req_stall;

   // Advance ring write index with wrap
   assign idx_in  = (idx_ff == IDX_LAST) ? '0 : idx_ff + 1'b1;
   assign rd_addr = req_accept ? idx_in : idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         wrapped_ff <= 1'b0;
      end else if (req_accept) begin
         idx_ff <= idx_in;
         if (idx_ff == IDX_LAST) begin
            wrapped_ff <= 1'b1;
         end
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         polarity_ff <= '0;
         enable_ff   <= '1;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_POLARITY: polarity_ff <= csr_wdata;
            CSR_ENABLE:   enable_ff   <= csr_wdata;
            default:      ;
         endcase
      end
   end

   // Sample ring
   diwvf_ram #(
      .WIDTH (CHANNELS),
      .DEPTH (SAMPLE_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (idx_ff),
      .wr_data (req_raw_sample),
      .rd_addr (rd_addr),
      .rd_data (old_sample)
   );

   assign lane_ctrl.accept    = req_accept;
   assign lane_ctrl.old_valid = wrapped_ff;

   // One counting lane per channel
   for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
      diwvf_lane #(
         .SAMPLE_DEPTH (SAMPLE_DEPTH)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (lane_ctrl),
         .new_bit (req_raw_sample[ch]),
         .old_bit (old_sample[ch]),
         .level   (level[ch])
      );
   end

   // Combine votes and hold results
   diwvf_merge #(
      .CHANNELS (CHANNELS)
   ) u_merge (
      .clock              (clock),
      .reset              (reset),
      .in_accept          (req_accept),
      .level              (level),
      .polarity           (polarity_ff),
      .enable             (enable_ff),
      .in_stall           (req_stall),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_adjusted_level (rsp_adjusted_level),
      .rsp_masked_status  (rsp_masked_status)
   );

endmodule

[rtl/diwvf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module diwvf_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/diwvf_lane.sv]
// One channel lane: running count of ones in the window and the vote.
module diwvf_lane #(
   parameter int SAMPLE_DEPTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  diwvf_pkg::lane_ctrl_type ctrl,
   input  logic                    new_bit,
   input  logic                    old_bit,
   output logic                    level
);
   import diwvf_pkg::*;

   localparam int CW         = $clog2(SAMPLE_DEPTH + 1);
   localparam int VOTE_LIMIT = SAMPLE_DEPTH - SAMPLE_DEPTH / 8;

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          old_live;

   // Drop the evicted sample, add the new one
   assign old_live = old_bit & ctrl.old_valid;
   assign count_in = count_ff + CW'(new_bit) - CW'(old_live);

   // Mostly-high window votes low
   assign level = (count_in <= CW'(VOTE_LIMIT));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctrl.accept) begin
         count_ff <= count_in;
      end
   end

endmodule

[rtl/diwvf_merge.sv]
// Merge stage: polarity and enable on the lane votes, two-entry result buffer.
module diwvf_merge #(
   parameter int CHANNELS = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_accept,
   input  logic [CHANNELS-1:0] level,
   input  logic [CHANNELS-1:0] polarity,
   input  logic [CHANNELS-1:0] enable,
   output logic                in_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [CHANNELS-1:0] rsp_adjusted_level,
   output logic [CHANNELS-1:0] rsp_masked_status
);

   logic [CHANNELS-1:0] adjusted;
   logic [CHANNELS-1:0] masked;
   logic                taken;

   logic                out_valid_ff;
   logic [CHANNELS-1:0] out_adj_ff;
   logic [CHANNELS-1:0] out_mask_ff;
   logic                skid_valid_ff;
   logic [CHANNELS-1:0] skid_adj_ff;
   logic [CHANNELS-1:0] skid_mask_ff;

   // Combine lane votes
   assign adjusted = ~(level ^ polarity);
   assign masked   = adjusted & enable;
   assign taken    = out_valid_ff & ~rsp_stall;

   // Control: output entry and skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (taken) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (in_accept) begin
         if (out_valid_ff && !taken) begin
            skid_valid_ff <= 1'b1;
         end
         out_valid_ff <= 1'b1;
      end else if (taken) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Payload: refill output from skid, else place the new transaction in output, or in skid if output is held
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (taken) begin
            out_adj_ff  <= skid_adj_ff;
            out_mask_ff <= skid_mask_ff;
         end
      end else if (in_accept) begin
         if (out_valid_ff && !taken) begin
            skid_adj_ff  <= adjusted;
            skid_mask_ff <= masked;
         end else begin
            out_adj_ff  <= adjusted;
            out_mask_ff <= masked;
         end
      end
   end

   assign in_stall           = skid_valid_ff;
   assign rsp_valid          = out_valid_ff;
   assign rsp_adjusted_level = out_adj_ff;
   assign rsp_masked_status  = out_mask_ff;

`ifndef SYNTH
   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without an output entry");

   a_skid_moves_out: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && taken) |=>
         (out_valid_ff && rsp_adjusted_level == $past(skid_adj_ff)
          && rsp_masked_status == $past(skid_mask_ff)))
      else $error("skid entry lost on hand-over");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (in_accept && !out_valid_ff) |=>
         (out_valid_ff && !skid_valid_ff && rsp_adjusted_level == $past(adjusted)))
      else $error("accepted transaction not placed in output entry");
`endif

endmodule

[tb/tb.sv]
// Self-checking testbench for the digital input window vote filter core.
`timescale 1ns / 1ps

module tb;
   import diwvf_pkg::*;

   localparam int SAMPLE_DEPTH   = 16;
   localparam int CHANNELS       = 4;
   localparam int VOTE_LIMIT     = SAMPLE_DEPTH - SAMPLE_DEPTH / 8;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int HOLDOFF_CYCLES = 40;
   localparam int MAX_GAP        = 20;
   localparam int SETTLE_CYCLES  = 8;

   // Register codes past the end of the list; writes to them are dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      logic [CHANNELS-1:0] adjusted;
      logic [CHANNELS-1:0] masked;
   } vote_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [CHANNELS-1:0]    req_raw_sample = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [CHANNELS-1:0]    rsp_adjusted_level;
   logic [CHANNELS-1:0]    rsp_masked_status;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CHANNELS-1:0]    csr_wdata = '0;

   // Shadow of the filter state and registers
   logic [CHANNELS-1:0] window_ring [SAMPLE_DEPTH];
   int                  window_wr_idx = 0;
   logic [CHANNELS-1:0] polarity_shadow = '0;
   logic [CHANNELS-1:0] enable_shadow = '1;

   vote_result_type pending_votes [$];

   int error_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int holdoff_requests = 0;
   int holdoff_served = 0;
   int holdoff_left = 0;

   digital_input_window_vote_filter_core #(
      .SAMPLE_DEPTH (SAMPLE_DEPTH),
      .CHANNELS     (CHANNELS)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_raw_sample     (req_raw_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_adjusted_level (rsp_adjusted_level),
      .rsp_masked_status  (rsp_masked_status),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Push the sample into the shadow window and vote every channel
   function automatic vote_result_type predict_vote(input logic [CHANNELS-1:0] sample);
      vote_result_type     res;
      logic [CHANNELS-1:0] level;
      int                  ones;
      window_ring[window_wr_idx] = sample;
      window_wr_idx = (window_wr_idx + 1) % SAMPLE_DEPTH;
      level = '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         ones = 0;
         for (int k = 0; k < SAMPLE_DEPTH; k++) begin
            ones += window_ring[k][ch];
         end
         // Nearly all ones reads low, anything else reads high
         if (ones <= VOTE_LIMIT) begin
            level[ch] = 1'b1;
         end
      end
      res.adjusted = ~(level ^ polarity_shadow);
      res.masked   = res.adjusted & enable_shadow;
      return res;
   endfunction

   // Bias each channel towards one with the given odds
   function automatic logic [CHANNELS-1:0] biased_sample(input int ones_pct);
      logic [CHANNELS-1:0] s;
      for (int b = 0; b < CHANNELS; b++) begin
         s[b] = ($urandom_range(99) < ones_pct);
      end
      return s;
   endfunction

   // Offer one sample transaction, hold it until taken, then idle at random
   task automatic send_sample(input logic [CHANNELS-1:0] sample);
      int gap;
      req_valid      <= 1'b1;
      req_raw_sample <= sample;
      do begin
         @(posedge clock);
      end while (req_stall);
      pending_votes.push_back(predict_vote(sample));
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering and wait for every outstanding result
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_votes.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Write one register; only called while the filter is idle
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CHANNELS-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      if (idx == CSR_POLARITY) begin
         polarity_shadow = data;
      end else if (idx == CSR_ENABLE) begin
         enable_shadow = data;
      end
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // Cleared window counts as all zeros
   task automatic test_reset_window();
      repeat (3) send_sample('0);
      wait_drained();
   endtask

   // Walk every channel through the vote threshold and back
   task automatic test_fill_threshold();
      repeat (SAMPLE_DEPTH) send_sample('1);
      repeat (3) send_sample('0);
      wait_drained();
   endtask

   // Register extremes, a mixed setting and the ignored spare codes
   task automatic test_register_writes();
      write_register(CSR_POLARITY, 4'hF);
      write_register(CSR_ENABLE, 4'h0);
      write_register(CSR_SPARE_A, 4'hF);
      write_register(CSR_SPARE_B, 4'hF);
      send_sample(4'h0);
      send_sample(4'hF);
      wait_drained();
      write_register(CSR_POLARITY, 4'h5);
      write_register(CSR_ENABLE, 4'hA);
      send_sample(4'h3);
      send_sample(4'hC);
      wait_drained();
      write_register(CSR_POLARITY, 4'h0);
      write_register(CSR_ENABLE, 4'hF);
   endtask

   // Hold the result side off while samples keep coming, then pause to drain
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      holdoff_requests++;
      repeat (24) send_sample(biased_sample(50));
      wait_drained();
   endtask

   // Bursts of near-full, near-empty and even traffic under one setting
   task automatic test_random_phase(input int count, input int idle_pct, input int stall_pct,
                                    input logic [CHANNELS-1:0] polarity,
                                    input logic [CHANNELS-1:0] enable);
      int ones_pct;
      int burst_left;
      write_register(CSR_POLARITY, polarity);
      write_register(CSR_ENABLE, enable);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      burst_left = 0;
      ones_pct = 50;
      for (int n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(40, 16);
            case ($urandom_range(3))
               0: ones_pct = 95;
               1: ones_pct = 5;
               2: ones_pct = 85;
               default: ones_pct = 50;
            endcase
         end
         burst_left--;
         send_sample(biased_sample(ones_pct));
      end
      wait_drained();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   // Drive result stall: long hold-off on request, random otherwise
   always @(posedge clock) begin
      if (holdoff_served != holdoff_requests) begin
         holdoff_left = HOLDOFF_CYCLES;
         holdoff_served++;
      end
      if (holdoff_left > 0) begin
         rsp_stall <= 1'b1;
         holdoff_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Compare each result transaction with the oldest prediction
   always @(posedge clock) begin : check_results
      vote_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_votes.size() == 0) begin
            $error("unexpected result: adjusted_level %h, masked_status %h",
                   rsp_adjusted_level, rsp_masked_status);
            error_count++;
         end else begin
            want = pending_votes.pop_front();
            if (rsp_adjusted_level !== want.adjusted) begin
               $error("adjusted_level: expected %h, got %h", want.adjusted, rsp_adjusted_level);
               error_count++;
            end
            if (rsp_masked_status !== want.masked) begin
               $error("masked_status: expected %h, got %h", want.masked, rsp_masked_status);
               error_count++;
            end
         end
      end
   end

   initial begin
      for (int k = 0; k < SAMPLE_DEPTH; k++) begin
         window_ring[k] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_window();
      test_fill_threshold();
      test_register_writes();
      test_backpressure();
      test_random_phase(105, 0, 0, 4'hF, 4'hF);
      test_random_phase(105, 57, 0, CHANNELS'($urandom_range(15)),
                        CHANNELS'($urandom_range(15)));
      test_random_phase(105, 0, 57, 4'h0, 4'h0);
      test_random_phase(105, 9, 9, CHANNELS'($urandom_range(15)),
                        CHANNELS'($urandom_range(15)));
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_votes.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
